### hw/rtl/scrolling_waveform_column_renderer_top_macros.svh
// Assertion macros used by the renderer's port checker.
`ifndef SCROLLING_WAVEFORM_COLUMN_RENDERER_TOP_MACROS_SVH
`define SCROLLING_WAVEFORM_COLUMN_RENDERER_TOP_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define SWCR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SWCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/swcr_pkg.sv
// Shared constants, types and tables of the scrolling waveform renderer.
package swcr_pkg;

  // Screen and field geometry
  localparam int SCREEN_COLUMNS = 128;
  localparam int HEAD_W         = $clog2(SCREEN_COLUMNS);
  localparam int COL_W          = 7;
  localparam int SAMPLE_W       = 16;
  localparam int PAGE_W         = 3;
  localparam int ROW_W          = 6;
  localparam int BYTE_W         = 8;
  localparam int MODE_W         = 3;
  localparam int SUM_W          = ((HEAD_W > COL_W) ? HEAD_W : COL_W) + 1;

  // Sample to row mapping
  localparam int SAT_W      = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int ROW_SHIFT  = 6;
  localparam logic [ROW_W-1:0] ROW_BOTTOM = 6'd63;

  // Test pattern constants
  localparam logic [BYTE_W-1:0] BYTE_ALL_ON  = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_AA      = 8'hAA;
  localparam logic [BYTE_W-1:0] BYTE_55      = 8'h55;
  localparam logic [BYTE_W-1:0] BYTE_OFF     = 8'h00;
  localparam logic [ROW_W-1:0]  SQUARE_LOW   = 6'd16;
  localparam logic [ROW_W-1:0]  SQUARE_HIGH  = 6'd48;
  localparam int                SQUARE_BIT   = 5;
  localparam int                SINE_LEN     = 32;
  localparam int                SINE_W       = $clog2(SINE_LEN);

  localparam logic [ROW_W-1:0] SINE_ROWS [SINE_LEN] = '{
    6'd32, 6'd38, 6'd44, 6'd49, 6'd54, 6'd58, 6'd61, 6'd63,
    6'd63, 6'd61, 6'd58, 6'd54, 6'd49, 6'd44, 6'd38, 6'd32,
    6'd31, 6'd25, 6'd19, 6'd14, 6'd9,  6'd5,  6'd2,  6'd0,
    6'd0,  6'd2,  6'd5,  6'd9,  6'd14, 6'd19, 6'd25, 6'd31
  };

  // Queue sizing
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAVE   = 3'd0,
    MODE_ALL_ON = 3'd1,
    MODE_AA     = 3'd2,
    MODE_55     = 3'd3,
    MODE_ODD    = 3'd4,
    MODE_EVEN   = 3'd5,
    MODE_SINE   = 3'd6,
    MODE_SQUARE = 3'd7
  } mode_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0] column;
  } cmd_t;

  // Byte of a page with rows top..bottom lit
  function automatic logic [BYTE_W-1:0] run_byte(input logic [PAGE_W-1:0] page,
                                                 input logic [ROW_W-1:0]  top,
                                                 input logic [ROW_W-1:0]  bottom);
    logic [BYTE_W-1:0] b;
    logic [ROW_W-1:0]  r;
    b = '0;
    for (int n = 0; n < BYTE_W; n++) begin
      r    = {page, 3'(n)};
      b[n] = (r >= top) && (r <= bottom);
    end
    return b;
  endfunction

endpackage

### hw/rtl/scrolling_waveform_column_renderer_top.sv
// Top level of the scrolling waveform column renderer.
// Scrolling oscilloscope view for a 128x64 page-organized monochrome panel. Push
// an item with operation 0 to store a sample in the ring (only in wave mode,
// otherwise it is dropped); push an item with operation 1 to get one pixel byte
// for a page and column, which shows up on the result side. Accepted items pass
// through a four-entry command queue to the back end, which takes one command
// per cycle, so up to one item per cycle is sustained while results are popped.
// After a read leaves the queue, its byte passes the registered two-port ring
// read and is then rendered into the four-entry result queue, where it becomes
// visible; reads wait when that queue is full. Ring entries never written
// since reset read as the bottom row, with no clearing pass. The display mode
// register is always ready and must only be written while the block is idle.
module scrolling_waveform_column_renderer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation,
  input  logic [swcr_pkg::SAMPLE_W-1:0] sample,
  input  logic [swcr_pkg::PAGE_W-1:0]   page,
  input  logic [swcr_pkg::COL_W-1:0]    column,
  output logic                          empty,
  input  logic                          pop,
  output logic [swcr_pkg::BYTE_W-1:0]   pixel_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swcr_pkg::MODE_W-1:0]   cfg_data
);

  swcr_pkg::mode_t display_mode;
  swcr_pkg::cmd_t  wr_cmd;
  swcr_pkg::cmd_t  rd_cmd;
  logic            q_wr;
  logic            q_rd;
  logic            q_full;
  logic            q_empty;

  // Mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= swcr_pkg::MODE_WAVE;
    end else if (cfg_valid && cfg_ready) begin
      display_mode <= swcr_pkg::mode_t'(cfg_data);
    end
  end

  swcr_front u_front (
    .push      (push),
    .full      (full),
    .operation (operation),
    .sample    (sample),
    .page      (page),
    .column    (column),
    .mode      (display_mode),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_cmd     (wr_cmd)
  );

  swcr_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  swcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (display_mode),
    .q_empty    (q_empty),
    .q_cmd      (rd_cmd),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .pixel_byte (pixel_byte)
  );

endmodule

### hw/rtl/swcr_ram.sv
// Generic RAM: one write port, two registered read ports.
module swcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/swcr_front.sv
// Front end: input handshake, sample-to-row mapping and command classification.
module swcr_front (
  input  logic                          push,
  output logic                          full,
  input  logic                          operation,
  input  logic [swcr_pkg::SAMPLE_W-1:0] sample,
  input  logic [swcr_pkg::PAGE_W-1:0]   page,
  input  logic [swcr_pkg::COL_W-1:0]    column,
  input  swcr_pkg::mode_t               mode,
  input  logic                          q_full,
  output logic                          q_wr,
  output swcr_pkg::cmd_t                q_cmd
);

  logic [swcr_pkg::SAT_W-1:0] sat;
  logic                       is_read;

  assign full    = q_full;
  assign is_read = (swcr_pkg::op_t'(operation) == swcr_pkg::OP_READ);

  // Saturate the conversion result, then map the top bits to a screen row
  always_comb begin
    if (sample > swcr_pkg::SAMPLE_W'(swcr_pkg::SAMPLE_MAX)) begin
      sat = '1;
    end else begin
      sat = sample[swcr_pkg::SAT_W-1:0];
    end
  end

  always_comb begin
    q_cmd.op     = swcr_pkg::op_t'(operation);
    q_cmd.row    = swcr_pkg::ROW_BOTTOM - sat[swcr_pkg::SAT_W-1:swcr_pkg::ROW_SHIFT];
    q_cmd.page   = page;
    q_cmd.column = column;
  end

  // Pushes outside wave mode are dropped here and never reach the queue
  assign q_wr = push && !q_full && (is_read || (mode == swcr_pkg::MODE_WAVE));

endmodule

### hw/rtl/swcr_cmd_fifo.sv
// Command queue between the front end and the back end.
module swcr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  swcr_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output swcr_pkg::cmd_t rd_cmd,
  output logic           empty
);

  swcr_pkg::cmd_t                  entries [swcr_pkg::CMDQ_DEPTH];
  logic [swcr_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [swcr_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [swcr_pkg::CMDQ_CNT_W-1:0] count;

  assign full   = (count == swcr_pkg::CMDQ_CNT_W'(swcr_pkg::CMDQ_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = entries[rd_ptr];

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + swcr_pkg::CMDQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + swcr_pkg::CMDQ_PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + swcr_pkg::CMDQ_CNT_W'(1);
        2'b01:   count <= count - swcr_pkg::CMDQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/swcr_back.sv
// Back end: ring writes, two-tap ring reads, byte rendering and result queue.
module swcr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  swcr_pkg::mode_t             mode,
  input  logic                        q_empty,
  input  swcr_pkg::cmd_t              q_cmd,
  output logic                        q_rd,
  input  logic                        pop,
  output logic                        empty,
  output logic [swcr_pkg::BYTE_W-1:0] pixel_byte
);

  // Ring state
  logic [swcr_pkg::HEAD_W-1:0]         head;
  logic [swcr_pkg::HEAD_W-1:0]         head_next;
  logic [swcr_pkg::SCREEN_COLUMNS-1:0] valid;

  // Issue stage
  logic                        room;
  logic                        issue;
  logic                        is_push;
  logic [swcr_pkg::COL_W-1:0]  col_prev;
  logic [swcr_pkg::HEAD_W-1:0] idx_a;
  logic [swcr_pkg::HEAD_W-1:0] idx_b;

  // Render stage
  logic                        sb_valid;
  logic [swcr_pkg::PAGE_W-1:0] sb_page;
  logic [swcr_pkg::COL_W-1:0]  sb_col;
  logic                        sb_va;
  logic                        sb_vb;
  logic [swcr_pkg::ROW_W-1:0]  rdata_a;
  logic [swcr_pkg::ROW_W-1:0]  rdata_b;
  logic [swcr_pkg::ROW_W-1:0]  row_a;
  logic [swcr_pkg::ROW_W-1:0]  row_b;
  logic [swcr_pkg::ROW_W-1:0]  top;
  logic [swcr_pkg::ROW_W-1:0]  bottom;
  logic [swcr_pkg::ROW_W-1:0]  pat_row;
  logic [swcr_pkg::BYTE_W-1:0] byte_out;

  // Result queue
  logic [swcr_pkg::BYTE_W-1:0]     out_mem [swcr_pkg::OUTQ_DEPTH];
  logic [swcr_pkg::OUTQ_PTR_W-1:0] out_wr_ptr;
  logic [swcr_pkg::OUTQ_PTR_W-1:0] out_rd_ptr;
  logic [swcr_pkg::OUTQ_CNT_W-1:0] out_count;
  logic                            out_pop;

  // Ring position of head + offset, wrapped once; out-of-range folds to 0
  function automatic logic [swcr_pkg::HEAD_W-1:0] ring_index(
      input logic [swcr_pkg::HEAD_W-1:0] base,
      input logic [swcr_pkg::COL_W-1:0]  offset);
    logic [swcr_pkg::SUM_W-1:0] s;
    s = swcr_pkg::SUM_W'(base) + swcr_pkg::SUM_W'(offset);
    if (s >= swcr_pkg::SUM_W'(swcr_pkg::SCREEN_COLUMNS)) begin
      s = s - swcr_pkg::SUM_W'(swcr_pkg::SCREEN_COLUMNS);
    end
    if (s >= swcr_pkg::SUM_W'(swcr_pkg::SCREEN_COLUMNS)) begin
      s = '0;
    end
    return s[swcr_pkg::HEAD_W-1:0];
  endfunction

  // Issue: pushes always go, reads only with a free result slot
  assign room    = (out_count + swcr_pkg::OUTQ_CNT_W'(sb_valid))
                   < swcr_pkg::OUTQ_CNT_W'(swcr_pkg::OUTQ_DEPTH);
  assign is_push = (q_cmd.op == swcr_pkg::OP_PUSH);
  assign issue   = !q_empty && (is_push || room);
  assign q_rd    = issue;

  // Left neighbor column; column 0 pairs with itself
  assign col_prev = (q_cmd.column == '0) ? q_cmd.column
                                         : q_cmd.column - swcr_pkg::COL_W'(1);
  assign idx_a    = ring_index(head, q_cmd.column);
  assign idx_b    = ring_index(head, col_prev);

  assign head_next = (head == swcr_pkg::HEAD_W'(swcr_pkg::SCREEN_COLUMNS - 1))
                     ? '0 : head + swcr_pkg::HEAD_W'(1);

  swcr_ram #(
    .WIDTH(swcr_pkg::ROW_W),
    .DEPTH(swcr_pkg::SCREEN_COLUMNS)
  ) u_ring (
    .clk     (clk),
    .we      (issue && is_push),
    .waddr   (head),
    .wdata   (q_cmd.row),
    .raddr_a (idx_a),
    .raddr_b (idx_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Head and per-entry written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      valid <= '0;
    end else if (issue && is_push) begin
      head        <= head_next;
      valid[head] <= 1'b1;
    end
  end

  // Render stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else begin
      sb_valid <= issue && !is_push;
    end
  end

  // Render stage payload
  always_ff @(posedge clk) begin
    sb_page <= q_cmd.page;
    sb_col  <= q_cmd.column;
    sb_va   <= valid[idx_a];
    sb_vb   <= valid[idx_b];
  end

  // Unwritten entries sit on the bottom row
  assign row_a  = sb_va ? rdata_a : swcr_pkg::ROW_BOTTOM;
  assign row_b  = sb_vb ? rdata_b : swcr_pkg::ROW_BOTTOM;
  assign top    = (row_a < row_b) ? row_a : row_b;
  assign bottom = (row_a < row_b) ? row_b : row_a;

  assign pat_row = sb_col[swcr_pkg::SQUARE_BIT] ? swcr_pkg::SQUARE_HIGH
                                                : swcr_pkg::SQUARE_LOW;

  // Pattern select
  always_comb begin
    case (mode)
      swcr_pkg::MODE_WAVE:   byte_out = swcr_pkg::run_byte(sb_page, top, bottom);
      swcr_pkg::MODE_ALL_ON: byte_out = swcr_pkg::BYTE_ALL_ON;
      swcr_pkg::MODE_AA:     byte_out = swcr_pkg::BYTE_AA;
      swcr_pkg::MODE_55:     byte_out = swcr_pkg::BYTE_55;
      swcr_pkg::MODE_ODD:    byte_out = sb_col[0] ? swcr_pkg::BYTE_ALL_ON
                                                  : swcr_pkg::BYTE_OFF;
      swcr_pkg::MODE_EVEN:   byte_out = sb_col[0] ? swcr_pkg::BYTE_OFF
                                                  : swcr_pkg::BYTE_ALL_ON;
      swcr_pkg::MODE_SINE:   byte_out = swcr_pkg::run_byte(sb_page,
                               swcr_pkg::SINE_ROWS[sb_col[swcr_pkg::SINE_W-1:0]],
                               swcr_pkg::SINE_ROWS[sb_col[swcr_pkg::SINE_W-1:0]]);
      swcr_pkg::MODE_SQUARE: byte_out = swcr_pkg::run_byte(sb_page, pat_row, pat_row);
      default:               byte_out = swcr_pkg::BYTE_OFF;
    endcase
    // Columns past the screen edge are dark
    if ({1'b0, sb_col} >= (swcr_pkg::COL_W + 1)'(swcr_pkg::SCREEN_COLUMNS)) begin
      byte_out = swcr_pkg::BYTE_OFF;
    end
  end

  // Result queue
  assign empty      = (out_count == '0);
  assign pixel_byte = out_mem[out_rd_ptr];
  assign out_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (sb_valid) begin
      out_mem[out_wr_ptr] <= byte_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (sb_valid) begin
        out_wr_ptr <= out_wr_ptr + swcr_pkg::OUTQ_PTR_W'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + swcr_pkg::OUTQ_PTR_W'(1);
      end
      case ({sb_valid, out_pop})
        2'b10:   out_count <= out_count + swcr_pkg::OUTQ_CNT_W'(1);
        2'b01:   out_count <= out_count - swcr_pkg::OUTQ_CNT_W'(1);
        default: out_count <= out_count;
      endcase
    end
  end

endmodule

### hw/rtl/swcr_port_checker.sv
// Port-level checker for the renderer, bound to the top level.
`include "scrolling_waveform_column_renderer_top_macros.svh"

module swcr_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [swcr_pkg::BYTE_W-1:0] pixel_byte,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // Reset flushes both queues
  `SWCR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result side not empty after reset")
  `SWCR_ASSERT_ALWAYS(a_reset_not_full, clk, rst |=> !full, "input side full after reset")

  // A waiting result holds until it is popped
  `SWCR_ASSERT(a_result_hold, clk, rst, !empty && !pop |=> !empty && $stable(pixel_byte), "waiting result changed before pop")

  // Mode register never back-pressures
  `SWCR_ASSERT(a_cfg_ready, clk, rst, cfg_valid |-> cfg_ready, "mode write stalled")

endmodule

bind scrolling_waveform_column_renderer_top swcr_port_checker u_port_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .pixel_byte (pixel_byte),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
